// ===== rtl/core/gerot_pkg.sv =====
// Shared types, widths and rotation coefficients for the galactic rotation core.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps
package gerot_pkg;

  localparam int IN_W   = 32;
  localparam int FRAC_W = 30;
  localparam int OUT_W  = FRAC_W + 2;
  localparam int CO_W   = 32;
  localparam int A_W    = 32;
  localparam int LEN_W  = $clog2(IN_W + 1);
  localparam int PROD_W = CO_W + A_W;
  localparam int SUM_W  = 64;
  localparam int W_W    = PROD_W + 2;
  localparam int WMAG_W = W_W - 1;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = SUM_W + 2;
  localparam int QB     = FRAC_W + 3;
  localparam int NUM_SH = FRAC_W - 30;
  localparam int NUM_LSH = (NUM_SH > 0) ? NUM_SH : 0;
  localparam int NUM_RSH = (NUM_SH < 0) ? -NUM_SH : 0;
  localparam int NUM_W  = WMAG_W + NUM_LSH;
  localparam int DW     = (NUM_W > ROOT_W + QB) ? NUM_W : ROOT_W + QB;
  localparam longint unsigned DEC_SCALE = 64'd1000000000000;

  typedef struct packed {
    logic                    req_type;
    logic signed [IN_W-1:0]  in_x;
    logic signed [IN_W-1:0]  in_y;
    logic signed [IN_W-1:0]  in_z;
  } src_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    zero_vector;
  } res_t;

  typedef struct packed {
    logic                  req;
    logic                  zero;
    logic [2:0][A_W-1:0]   a;
  } norm_t;

  typedef struct packed {
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][WMAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    logic               zero;
    logic [2:0]         neg;
    logic [2:0][QB-1:0] q;
  } quo_t;

  // Decimal coefficient (scaled by 1e12) to Q1.31, rounded half up.
  function automatic logic signed [CO_W-1:0] q31m(input longint unsigned m);
    longint unsigned t;
    longint unsigned hi;
    longint unsigned lo;
    t  = m * 64'd65536;
    hi = (t / DEC_SCALE) * 64'd32768;
    lo = (((t % DEC_SCALE) * 64'd32768) + DEC_SCALE / 64'd2) / DEC_SCALE;
    return CO_W'(hi + lo);
  endfunction

  // ROT[col][row], column-major equatorial-to-galactic matrix.
  localparam logic signed [CO_W-1:0] ROT [3][3] = '{
    '{-q31m(64'd54875539390),  q31m(64'd494109453633), -q31m(64'd867666135681)},
    '{-q31m(64'd873437104725), -q31m(64'd444829594298), -q31m(64'd198076389622)},
    '{-q31m(64'd483834991775),  q31m(64'd746982248696),  q31m(64'd455983794523)}
  };

endpackage

// ===== rtl/core/gerot_norm.sv =====
// Block scaling front end: absolute values, bit length of the largest, shift to 31 bits.
// Depends on gerot_pkg.
`timescale 1ns / 1ps
module gerot_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  gerot_pkg::src_t src,
  output logic            out_vld,
  output gerot_pkg::norm_t nrm
);
  import gerot_pkg::*;

  logic [2:0][IN_W-1:0] vec;
  logic [2:0][IN_W-1:0] mag1, mag1_next, mag2;
  logic [2:0]           neg1, neg1_next, neg2;
  logic                 req1, req2;
  logic                 v1, v2, v3;
  logic [IN_W-1:0]      or_all;
  logic [LEN_W-1:0]     len2, len2_next;
  logic                 zero2;
  logic [IN_W+A_W-2:0]  wide [3];
  logic [2:0][A_W-1:0]  a_next;
  norm_t                nrm_q;

  assign vec[0] = src.in_x;
  assign vec[1] = src.in_y;
  assign vec[2] = src.in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_next[i] = vec[i][IN_W-1];
      mag1_next[i] = neg1_next[i] ? (~vec[i] + IN_W'(1)) : vec[i];
    end
  end

  assign or_all = mag1[0] | mag1[1] | mag1[2];

  always_comb begin
    len2_next = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (or_all[k]) begin
        len2_next = LEN_W'(k + 1);
      end
    end
  end

  // Shifting left by 31 and right by the bit length covers both directions.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i]   = {mag2[i], {(A_W-1){1'b0}}} >> len2;
      a_next[i] = neg2[i] ? -{1'b0, wide[i][A_W-2:0]} : {1'b0, wide[i][A_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1       <= mag1_next;
      neg1       <= neg1_next;
      req1       <= src.req_type;
      mag2       <= mag1;
      neg2       <= neg1;
      req2       <= req1;
      len2       <= len2_next;
      zero2      <= (or_all == '0);
      nrm_q.a    <= a_next;
      nrm_q.req  <= req2;
      nrm_q.zero <= zero2;
    end
  end

  assign out_vld = v3;
  assign nrm     = nrm_q;
endmodule

// ===== rtl/core/gerot_mac.sv =====
// Rotation products, sum of squares and row sums, then row magnitudes and signs.
// Depends on gerot_pkg for the coefficient matrix and stage types.
`timescale 1ns / 1ps
module gerot_mac (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  gerot_pkg::norm_t  nrm,
  output logic              out_vld,
  output logic [gerot_pkg::SUM_W-1:0] sq_sum,
  output gerot_pkg::side_t  side
);
  import gerot_pkg::*;

  logic signed [PROD_W-1:0] prod1 [3][3];
  logic signed [PROD_W-1:0] prod1_next [3][3];
  logic signed [PROD_W-1:0] sq1 [3];
  logic signed [PROD_W-1:0] sq1_next [3];
  logic signed [CO_W-1:0]   coef;
  logic signed [A_W-1:0]    a_s;
  logic                     zero1, zero2;
  logic signed [W_W-1:0]    w2 [3];
  logic signed [W_W-1:0]    w2_next [3];
  logic [SUM_W-1:0]         s2, s2_next;
  logic                     v1, v2, v3;
  side_t                    side_q, side_next;
  logic [SUM_W-1:0]         s3;

  always_comb begin
    coef = '0;
    a_s  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef = nrm.req ? ROT[c][r] : ROT[r][c];
        a_s  = $signed(nrm.a[c]);
        prod1_next[r][c] = coef * a_s;
      end
      a_s = $signed(nrm.a[r]);
      sq1_next[r] = a_s * a_s;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      w2_next[r] = W_W'(prod1[r][0]) + W_W'(prod1[r][1]) + W_W'(prod1[r][2]);
    end
    s2_next = SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]);
  end

  always_comb begin
    side_next.zero = zero2;
    for (int r = 0; r < 3; r++) begin
      side_next.neg[r] = w2[r][W_W-1];
      side_next.mag[r] = side_next.neg[r] ? WMAG_W'(-w2[r]) : WMAG_W'(w2[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1  <= prod1_next;
      sq1    <= sq1_next;
      zero1  <= nrm.zero;
      w2     <= w2_next;
      s2     <= s2_next;
      zero2  <= zero1;
      side_q <= side_next;
      s3     <= s2;
    end
  end

  assign out_vld = v3;
  assign sq_sum  = s3;
  assign side    = side_q;
endmodule

// ===== rtl/core/gerot_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, carrying the row data alongside.
// Depends on gerot_pkg.
`timescale 1ns / 1ps
module gerot_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [gerot_pkg::SUM_W-1:0] sq_sum,
  input  gerot_pkg::side_t  side_in,
  output logic              out_vld,
  output logic [gerot_pkg::ROOT_W-1:0] root,
  output gerot_pkg::side_t  side_out
);
  import gerot_pkg::*;

  logic [ROOT_W:0]   vld;
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  side_t             side_q [ROOT_W+1];

  assign vld[0]    = in_vld;
  assign root_q[0] = '0;
  assign rem_q[0]  = REM_W'(sq_sum);
  assign side_q[0] = side_in;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int K = ROOT_W - 1 - g;
    logic [REM_W-1:0] trial;
    logic             ge;

    // Setting bit K grows the square by root*2^(K+1) + 2^(2K).
    assign trial = (REM_W'(root_q[g]) << (K + 1)) + (REM_W'(1) << (2 * K));
    assign ge    = (rem_q[g] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_q[g+1] <= ge ? (root_q[g] | (ROOT_W'(1) << K)) : root_q[g];
        rem_q[g+1]  <= ge ? (rem_q[g] - trial) : rem_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign out_vld  = vld[ROOT_W];
  assign root     = root_q[ROOT_W];
  assign side_out = side_q[ROOT_W];
endmodule

// ===== rtl/core/gerot_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage: |w| scaled over root.
// Depends on gerot_pkg.
`timescale 1ns / 1ps
module gerot_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [gerot_pkg::ROOT_W-1:0] root,
  input  gerot_pkg::side_t  side,
  output logic              out_vld,
  output gerot_pkg::quo_t   quo
);
  import gerot_pkg::*;

  logic [QB:0]         vld;
  logic [DW-1:0]       rem_q [QB+1][3];
  logic [QB-1:0]       q_q   [QB+1][3];
  logic [ROOT_W-1:0]   r_q   [QB+1];
  logic [2:0]          neg_q [QB+1];
  logic [QB:0]         zero_q;

  assign vld[0]    = in_vld;
  assign r_q[0]    = root;
  assign neg_q[0]  = side.neg;
  assign zero_q[0] = side.zero;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_q[0][l] = (DW'(side.mag[l]) << NUM_LSH) >> NUM_RSH;
      q_q[0][l]   = '0;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    localparam int K = QB - 1 - g;
    logic [DW-1:0] trial;
    logic [2:0]    ge;

    assign trial = DW'(r_q[g]) << K;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = (rem_q[g][l] >= trial);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[g+1][l] <= ge[l] ? (rem_q[g][l] - trial) : rem_q[g][l];
          q_q[g+1][l]   <= ge[l] ? (q_q[g][l] | (QB'(1) << K)) : q_q[g][l];
        end
        r_q[g+1]    <= r_q[g];
        neg_q[g+1]  <= neg_q[g];
        zero_q[g+1] <= zero_q[g];
      end
    end
  end

  always_comb begin
    quo.zero = zero_q[QB];
    quo.neg  = neg_q[QB];
    for (int l = 0; l < 3; l++) begin
      quo.q[l] = q_q[QB][l];
    end
  end

  assign out_vld = vld[QB];
endmodule

// ===== rtl/core/galactic_equatorial_rotation_core.sv =====
// Top level of the J2000 equatorial/galactic rotation core: pipeline chain and output register.
// Depends on gerot_pkg, gerot_norm, gerot_mac, gerot_sqrt and gerot_div.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  src      | src_valid / src_stall  | src_data  (req_type, in_x, in_y, in_z)
//  res      | res_valid / res_stall  | res_data  (out_x, out_y, out_z, zero_vector)
//
// One transaction per cycle is accepted while the pipeline advances; each result passes through
// 3 scaling, 3 multiply-accumulate, 32 square-root and 33 divider stages and 1 output register.
// The whole pipeline advances together; it holds only while a result waits under res_stall,
// and then src_stall is raised in the same cycle.
// Synchronous reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module galactic_equatorial_rotation_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  gerot_pkg::src_t src_data,
  output logic            res_valid,
  input  logic            res_stall,
  output gerot_pkg::res_t res_data
);
  import gerot_pkg::*;

  logic                 adv;
  logic                 n_vld, m_vld, s_vld, d_vld;
  norm_t                nrm;
  logic [SUM_W-1:0]     sq_sum;
  side_t                m_side, s_side;
  logic [ROOT_W-1:0]    root;
  quo_t                 quo;
  logic [QB:0]          qr [3];
  logic [FRAC_W:0]      qs [3];
  logic signed [OUT_W-1:0] o [3];
  res_t                 res_next;
  res_t                 res_q;
  logic                 res_vld;

  assign adv       = !(res_vld && res_stall);
  assign src_stall = !adv;

  gerot_norm u_norm (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(src_valid), .src(src_data),
    .out_vld(n_vld), .nrm(nrm)
  );

  gerot_mac u_mac (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(n_vld), .nrm(nrm),
    .out_vld(m_vld), .sq_sum(sq_sum), .side(m_side)
  );

  gerot_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(m_vld), .sq_sum(sq_sum), .side_in(m_side),
    .out_vld(s_vld), .root(root), .side_out(s_side)
  );

  gerot_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(s_vld), .root(root), .side(s_side),
    .out_vld(d_vld), .quo(quo)
  );

  // Round half up from the extra quotient bit, saturate at one, then restore the sign; a zero vector gives all zeros.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qr[l] = ({1'b0, quo.q[l]} + (QB + 1)'(1)) >> 1;
      if (qr[l] > (QB + 1)'(1) << FRAC_W) begin
        qs[l] = (FRAC_W + 1)'(1) << FRAC_W;
      end else begin
        qs[l] = qr[l][FRAC_W:0];
      end
      if (quo.zero) begin
        o[l] = '0;
      end else if (quo.neg[l]) begin
        o[l] = -$signed(OUT_W'(qs[l]));
      end else begin
        o[l] = $signed(OUT_W'(qs[l]));
      end
    end
    res_next.out_x       = o[0];
    res_next.out_y       = o[1];
    res_next.out_z       = o[2];
    res_next.zero_vector = quo.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign res_valid = res_vld;
  assign res_data  = res_q;
endmodule

// ===== rtl/core/gerot_chk.sv =====
// Port-level checker for the rotation core, attached to the top level by bind.
// Depends on gerot_pkg and galactic_equatorial_rotation_core.
`timescale 1ns / 1ps
module gerot_chk (
  input logic            clk,
  input logic            rst,
  input logic            src_stall,
  input logic            res_valid,
  input logic            res_stall,
  input gerot_pkg::res_t res_data
);
  import gerot_pkg::*;

  localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_W;

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (res_valid && res_stall))
    else $error("input stalled without a waiting result");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.zero_vector) |->
      (res_data.out_x == '0 && res_data.out_y == '0 && res_data.out_z == '0))
    else $error("zero vector with nonzero output");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.out_x <= ONE && res_data.out_x >= -ONE &&
                   res_data.out_y <= ONE && res_data.out_y >= -ONE &&
                   res_data.out_z <= ONE && res_data.out_z >= -ONE))
    else $error("output component beyond one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");
endmodule

bind galactic_equatorial_rotation_core gerot_chk u_gerot_chk (.*);
